@@ design/pfdfd_pkg.sv @@
// ---------------------------------------------------------------------------
// PFD with fractional divider: shared package
// Types and constants shared by the core and its step logic.
// ---------------------------------------------------------------------------
`default_nettype none

package pfdfd_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_DIVIDE_RATIO      = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRACTIONAL_ENABLE = 1'b1;

    localparam int unsigned RATIO_W      = 16;
    localparam int unsigned COUNT_W      = 16;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd2400;

    localparam int unsigned TDATA_W = 8;

    // One input item.
    typedef struct packed {
        logic after_first_period;
        logic reset_elapsed;
        logic extremum_is_minimum;
        logic vco_extremum;
        logic ref_edge;
    } t_item;

    // One result item.
    typedef struct packed {
        logic reset_pending;
        logic reset_start;
        logic divider_level;
        logic down_pulse;
        logic up_pulse;
    } t_result;

    // Detector and divider state, apart from the sequence position.
    typedef struct packed {
        logic [COUNT_W-1:0] minimum_count;
        logic               divider_out;
        logic               up_flag;
        logic               down_flag;
        logic               waiting_reset;
    } t_state;

endpackage

`default_nettype wire

@@ design/pfd_with_fractional_divider_core.sv @@
// An accepted item is held in the input stage register, and its result in the
// result register until taken. Throughput: one item per cycle when the result
// stream does not stall; the state update is a single pass of a 16-bit
// increment and compare against the half-period threshold. The block takes a
// new item while a result waits, as long as its input stage can move or is
// empty. Reset is synchronous and active low; it clears the divider, detector
// flags, sequence position and stage valids, and resets the config registers.
// ---------------------------------------------------------------------------
// PFD with fractional divider: top level
// Divide-by-N or N/N+1 feedback divider and phase-frequency detector,
// one event slot per item, stream channels on both sides.
// ---------------------------------------------------------------------------
`default_nettype none

module pfd_with_fractional_divider_core #(
    parameter int SEQ_LEN = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [pfdfd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [pfdfd_pkg::RATIO_W-1:0]      i_cfg_wdata,
    // Input item stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] ref_edge, [1] vco_extremum, [2] extremum_is_minimum,
    // [3] reset_elapsed, [4] after_first_period, [7:5] zero.
    input  logic [pfdfd_pkg::TDATA_W-1:0]      s_axis_tdata,
    // Result item stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] up_pulse, [1] down_pulse, [2] divider_level,
    // [3] reset_start, [4] reset_pending, [7:5] zero.
    output logic [pfdfd_pkg::TDATA_W-1:0]      m_axis_tdata
);
    import pfdfd_pkg::*;

    localparam int SEQ_W = $clog2(SEQ_LEN);

    logic [RATIO_W-1:0] r_divide_ratio;
    logic               r_fractional_enable;

    t_state             r_state;
    t_state             n_state;
    logic [SEQ_W-1:0]   r_seq_idx;
    logic [SEQ_W-1:0]   n_seq_idx;
    logic               n_reset_start;

    t_item              r_item;
    logic               r_item_valid;
    t_result            r_result;
    logic               r_result_valid;

    logic               advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide_ratio      <= RATIO_RESET;
            r_fractional_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DIVIDE_RATIO:      r_divide_ratio      <= i_cfg_wdata;
                REG_FRACTIONAL_ENABLE: r_fractional_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The input stage moves on whenever the result register is free or drains.
    assign advance       = r_item_valid && (!r_result_valid || m_axis_tready);
    assign s_axis_tready = !r_item_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_item_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= t_item'(s_axis_tdata[$bits(t_item)-1:0]);
        end
    end

    pfdfd_step #(
        .SEQ_LEN(SEQ_LEN)
    ) u_step (
        .i_state             (r_state),
        .i_seq_idx           (r_seq_idx),
        .i_divide_ratio      (r_divide_ratio),
        .i_fractional_enable (r_fractional_enable),
        .i_item              (r_item),
        .o_state             (n_state),
        .o_seq_idx           (n_seq_idx),
        .o_reset_start       (n_reset_start)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= '0;
            r_seq_idx      <= '0;
            r_result_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state        <= n_state;
                r_seq_idx      <= n_seq_idx;
                r_result_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_result_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result.up_pulse      <= n_state.up_flag;
            r_result.down_pulse    <= n_state.down_flag;
            r_result.divider_level <= n_state.divider_out;
            r_result.reset_start   <= n_reset_start;
            r_result.reset_pending <= n_state.waiting_reset;
        end
    end

    assign m_axis_tvalid = r_result_valid;
    assign m_axis_tdata  = {(TDATA_W-$bits(t_result))'(0), r_result};

endmodule

`default_nettype wire

@@ design/pfdfd_step.sv @@
// ---------------------------------------------------------------------------
// PFD with fractional divider: per-item step logic
// Combinational next state of the divider and phase-frequency detector.
// ---------------------------------------------------------------------------
`default_nettype none

module pfdfd_step #(
    parameter int SEQ_LEN = 2
) (
    input  pfdfd_pkg::t_state                  i_state,
    input  logic [$clog2(SEQ_LEN)-1:0]         i_seq_idx,
    input  logic [pfdfd_pkg::RATIO_W-1:0]      i_divide_ratio,
    input  logic                               i_fractional_enable,
    input  pfdfd_pkg::t_item                   i_item,
    output pfdfd_pkg::t_state                  o_state,
    output logic [$clog2(SEQ_LEN)-1:0]         o_seq_idx,
    output logic                               o_reset_start
);
    import pfdfd_pkg::*;

    localparam int SEQ_W = $clog2(SEQ_LEN);
    localparam logic [SEQ_W:0]   SEQ_HALF = (SEQ_W+1)'(SEQ_LEN / 2);
    localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_LEN - 1);

    logic [RATIO_W:0]   ratio;
    logic [COUNT_W-1:0] thr;
    logic [COUNT_W-1:0] count_inc;
    logic               use_plus_one;

    always_comb begin
        use_plus_one = i_fractional_enable && ({1'b0, i_seq_idx} >= SEQ_HALF);
        ratio        = {1'b0, i_divide_ratio} + {{RATIO_W{1'b0}}, use_plus_one};
        // Low half waits ceil(R/2) minima, high half floor(R/2).
        thr = i_state.divider_out ? ratio[RATIO_W:1]
                                  : ratio[RATIO_W:1] + {{(COUNT_W-1){1'b0}}, ratio[0]};
        if (thr == '0) begin
            thr = COUNT_W'(1);
        end
        count_inc = i_state.minimum_count + COUNT_W'(1);

        o_state       = i_state;
        o_seq_idx     = i_seq_idx;
        o_reset_start = 1'b0;

        if (i_item.after_first_period) begin
            if (i_item.ref_edge) begin
                o_state.up_flag = 1'b1;
            end
            if (i_item.vco_extremum && i_item.extremum_is_minimum) begin
                o_state.minimum_count = count_inc;
                if (count_inc >= thr) begin
                    o_state.minimum_count = '0;
                    o_state.divider_out   = ~i_state.divider_out;
                    // Rising edge of the divider output.
                    if (!i_state.divider_out) begin
                        o_state.down_flag = 1'b1;
                        if (i_fractional_enable) begin
                            o_seq_idx = (i_seq_idx == SEQ_LAST) ? '0
                                                                : i_seq_idx + SEQ_W'(1);
                        end
                    end
                end
            end
            if (i_item.reset_elapsed) begin
                o_state.up_flag       = 1'b0;
                o_state.down_flag     = 1'b0;
                o_state.waiting_reset = 1'b0;
            end
            if (o_state.up_flag && o_state.down_flag && !o_state.waiting_reset) begin
                o_state.waiting_reset = 1'b1;
                o_reset_start         = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/pfdfd_checker.sv @@
// ---------------------------------------------------------------------------
// PFD with fractional divider: port checker
// Concurrent checks on the top-level ports, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

module pfdfd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Nothing is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A reset start only happens with both flags up, and marks the reset pending.
    a_start_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |->
            m_axis_tdata[0] && m_axis_tdata[1] && m_axis_tdata[4])
        else $error("reset start without both flags");

    // The flags are only cleared together with the pending mark.
    a_pending_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[0] && m_axis_tdata[1])
        else $error("reset pending without both flags");

endmodule

bind pfd_with_fractional_divider_core pfdfd_checker u_pfdfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
